>>> hw/rtl/sstk_pkg.sv
// ============================================================================
// Segmented stack package
// Shared constants, operation and status codes, and the item types of the
// segmented stack.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sstk_pkg;

    localparam int NUM_SEGMENTS_DEF  = 16;
    localparam int SEGMENT_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF    = 32;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd2;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_POP_AT = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
        logic [3:0]         segment_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_value;
        logic [4:0]         segments_used;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/segmented_stack_with_pop_at.sv
// ============================================================================
// Segmented stack with pop-at
// A stack split into segments of configurable capacity, with push, pop and pop
// of the top of any chosen segment. Trailing empty segments are released.
// ============================================================================
//
//  Channel | Signals                          | Direction | Moves
//  --------+----------------------------------+-----------+---------------------
//  in      | i_in_valid, o_in_ready, i_in_item  | input     | one operation item
//  out     | o_out_valid, i_out_ready, o_out_item | output  | one result item
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data | input   | segment capacity
//
// An item that reaches the fill memory (every push, and a pop or pop-at that is
// not refused) passes through the fill, top, top-read and done states; one that
// is refused or ignored at once skips the fill state, and both skip the top-read
// state when no segment is in use after the item. Reset is synchronous and needs
// no clearing pass. The output register holds a finished result while the next
// item is accepted; a stalled output holds the block in its final state.
`timescale 1ns / 1ps
`default_nettype none

module segmented_stack_with_pop_at #(
    parameter int NUM_SEGMENTS  = sstk_pkg::NUM_SEGMENTS_DEF,
    parameter int SEGMENT_DEPTH = sstk_pkg::SEGMENT_DEPTH_DEF,
    parameter int DATA_WIDTH    = sstk_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sstk_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sstk_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [sstk_pkg::CFG_W-1:0] i_cfg_data
);

    import sstk_pkg::*;

    localparam int SEG_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SEGMENTS + 1);
    localparam int FILL_W = $clog2(SEGMENT_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int IDX_W  = (CNT_W > 4) ? CNT_W : 4;
    localparam int USE_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int EXT_W  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int WORDS  = NUM_SEGMENTS * SEGMENT_DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [ADDR_W-1:0] SEG_STRIDE = ADDR_W'(SEGMENT_DEPTH);
    localparam logic [CMP_W-1:0]  CAP_MAX    = CMP_W'(SEGMENT_DEPTH);
    localparam logic [CNT_W-1:0]  SEG_COUNT  = CNT_W'(NUM_SEGMENTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_TOP  = 3'd2;
    localparam logic [2:0] S_TOPF = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [1:0]              r_op, n_op;
    logic [DATA_WIDTH-1:0]   r_val, n_val;
    logic [SEG_W-1:0]        r_seg, n_seg;
    logic [1:0]              r_status, n_status;
    logic [NUM_SEGMENTS-1:0] r_flags, n_flags;
    logic [CFG_W-1:0]        r_cap;
    logic                    r_empty, n_empty;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_item, n_out_item;

    logic [FILL_W-1:0]       r_fill_mem [NUM_SEGMENTS];
    logic [FILL_W-1:0]       r_fill_rd;
    logic [DATA_WIDTH-1:0]   r_elem_mem [WORDS];
    logic [DATA_WIDTH-1:0]   r_elem_rd;

    logic                    fill_re, fill_we;
    logic [SEG_W-1:0]        fill_raddr, fill_waddr;
    logic [FILL_W-1:0]       fill_wdata;
    logic                    elem_re, elem_we;
    logic [ADDR_W-1:0]       elem_raddr, elem_waddr;
    logic [DATA_WIDTH-1:0]   elem_wdata;

    logic [CNT_W-1:0]        used;
    logic [SEG_W-1:0]        last_seg;
    logic [IDX_W-1:0]        idx_ext;
    logic [SEG_W-1:0]        idx_seg;
    logic                    idx_in;
    logic [FILL_W-1:0]       f_cur;
    logic [CMP_W-1:0]        cap_eff;
    logic                    open_seg;
    logic [SEG_W-1:0]        wseg;
    logic [FILL_W-1:0]       slot;
    logic [EXT_W-1:0]        val_ext;
    logic [EXT_W-1:0]        top_ext;
    logic [USE_W-1:0]        used_ext;
    logic                    in_acc;
    logic                    out_load;

    sstk_seg_scan #(
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .CNT_W        (CNT_W)
    ) u_scan (
        .i_flags (r_flags),
        .o_used  (used)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign in_acc   = i_in_valid && o_in_ready;
    assign last_seg = SEG_W'(used - CNT_W'(1));
    assign idx_ext  = IDX_W'(i_in_item.segment_index);
    assign idx_seg  = SEG_W'(i_in_item.segment_index);
    assign idx_in   = (idx_ext < IDX_W'(used)) ? r_flags[idx_seg] : 1'b0;
    assign f_cur    = r_flags[r_seg] ? r_fill_rd : '0;
    assign val_ext  = EXT_W'($unsigned(i_in_item.value));
    assign top_ext  = EXT_W'(r_elem_rd);
    assign used_ext = USE_W'(used);

    always_comb begin
        cap_eff = CMP_W'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end
        if (cap_eff > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_seg       = r_seg;
        n_status    = r_status;
        n_flags     = r_flags;
        n_empty     = r_empty;
        n_out_item  = r_out_item;
        fill_re     = 1'b0;
        fill_raddr  = last_seg;
        fill_we     = 1'b0;
        fill_waddr  = r_seg;
        fill_wdata  = '0;
        elem_re     = 1'b0;
        elem_raddr  = ADDR_W'(last_seg) * SEG_STRIDE + ADDR_W'(r_fill_rd - FILL_W'(1));
        elem_we     = 1'b0;
        elem_wdata  = r_val;
        open_seg    = (used == '0) || (CMP_W'(f_cur) >= cap_eff);
        wseg        = open_seg ? SEG_W'(used) : r_seg;
        slot        = open_seg ? '0 : f_cur;
        elem_waddr  = ADDR_W'(wseg) * SEG_STRIDE + ADDR_W'(slot);
        out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_in_item.operation;
                    n_val    = val_ext[DATA_WIDTH-1:0];
                    n_status = ST_OK;
                    n_state  = S_TOP;
                    unique case (i_in_item.operation)
                        OP_PUSH: begin
                            n_seg      = (used == '0) ? '0 : last_seg;
                            fill_re    = 1'b1;
                            fill_raddr = (used == '0) ? '0 : last_seg;
                            n_state    = S_FILL;
                        end
                        OP_POP: begin
                            if (used == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_seg   = last_seg;
                                fill_re = 1'b1;
                                n_state = S_FILL;
                            end
                        end
                        OP_POP_AT: begin
                            if (!idx_in) begin
                                n_status = ST_BAD;
                            end else begin
                                n_seg      = idx_seg;
                                fill_re    = 1'b1;
                                fill_raddr = idx_seg;
                                n_state    = S_FILL;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_FILL: begin
                n_state = S_TOP;
                unique case (r_op)
                    OP_PUSH: begin
                        if (open_seg && (used >= SEG_COUNT)) begin
                            n_status = ST_FULL;
                        end else begin
                            fill_we        = 1'b1;
                            fill_waddr     = wseg;
                            fill_wdata     = slot + FILL_W'(1);
                            elem_we        = 1'b1;
                            n_flags[wseg]  = 1'b1;
                        end
                    end
                    OP_POP, OP_POP_AT: begin
                        fill_we        = 1'b1;
                        fill_wdata     = f_cur - FILL_W'(1);
                        n_flags[r_seg] = (f_cur != FILL_W'(1));
                    end
                    default: begin
                        n_status = r_status;
                    end
                endcase
            end
            S_TOP: begin
                if (used == '0) begin
                    n_empty = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_empty = 1'b0;
                    fill_re = 1'b1;
                    n_state = S_TOPF;
                end
            end
            S_TOPF: begin
                elem_re = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load                 = 1'b1;
                    n_out_item.status        = r_status;
                    n_out_item.top_value     = r_empty ? '0 : $signed(top_ext[31:0]);
                    n_out_item.segments_used = used_ext[4:0];
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_seg      <= n_seg;
        r_status   <= n_status;
        r_empty    <= n_empty;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill_rd <= r_fill_mem[fill_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            r_elem_rd <= r_elem_mem[elem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sstk_seg_scan.sv
// ============================================================================
// Segment scan
// Priority encoder that turns the non-empty flags of all segments into the
// number of segments in use, one past the highest non-empty segment.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sstk_seg_scan #(
    parameter int NUM_SEGMENTS = 16,
    parameter int CNT_W        = 5
) (
    input  wire logic [NUM_SEGMENTS-1:0] i_flags,
    output logic      [CNT_W-1:0]        o_used
);

    always_comb begin
        o_used = '0;
        for (int i = 0; i < NUM_SEGMENTS; i++) begin
            if (i_flags[i]) begin
                o_used = CNT_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/segmented_stack_with_pop_at_test.sv
// ============================================================================
// Segmented stack with pop-at testbench
// Drives a short table of directed items and then random phases through the
// segmented stack, with the segment capacity rewritten between phases. A
// model of the stack in this file predicts every result, and each result is
// checked field by field against the oldest prediction. The sender works in
// bursts and the receiver stalls in patterns, with one long receiver hold-off.
// ============================================================================
`timescale 1ns / 1ps

module segmented_stack_with_pop_at_test;

    import sstk_pkg::*;

    localparam int NUM_SEG   = NUM_SEGMENTS_DEF;
    localparam int SEG_DEPTH = SEGMENT_DEPTH_DEF;

    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 95;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_in_item           in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;

    logic [31:0]        seg_mem [NUM_SEG][SEG_DEPTH];
    int unsigned        seg_fill [NUM_SEG];
    int unsigned        segs_used;
    logic [CFG_W-1:0]   seg_cap;

    t_out_item          expected_results [$];
    t_stim_row          directed_rows [$];
    t_out_item          want_r;

    int unsigned        items_sent;
    int unsigned        results_checked;
    int unsigned        mismatches;
    int unsigned        full_seen;
    int unsigned        empty_seen;
    int unsigned        bad_seen;
    int unsigned        burst_left;
    bit                 gaps_on;
    bit                 hold_req;
    int unsigned        hold_left;
    int unsigned        stall_mode;
    int unsigned        stall_count;

    segmented_stack_with_pop_at i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("segmented_stack_with_pop_at_test: FAIL");
        $finish;
    end

    function automatic void release_empty_tail();
        while (segs_used > 0 && seg_fill[segs_used - 1] == 0)
            segs_used--;
    endfunction

    task automatic stack_step(input t_in_item it, output t_out_item res);
        int unsigned cap;
        int unsigned last;
        logic [1:0]  st;
        cap = (seg_cap == 0) ? 1 : (seg_cap > SEG_DEPTH) ? SEG_DEPTH : seg_cap;
        st = ST_OK;
        case (it.operation)
            OP_PUSH: begin
                if (segs_used == 0 || seg_fill[segs_used - 1] >= cap) begin
                    if (segs_used >= NUM_SEG) begin
                        st = ST_FULL;
                    end else begin
                        seg_fill[segs_used] = 0;
                        segs_used++;
                    end
                end
                if (st == ST_OK) begin
                    last = segs_used - 1;
                    seg_mem[last][seg_fill[last]] = it.value;
                    seg_fill[last]++;
                end
            end
            OP_POP: begin
                if (segs_used == 0) begin
                    st = ST_EMPTY;
                end else begin
                    seg_fill[segs_used - 1]--;
                    release_empty_tail();
                end
            end
            OP_POP_AT: begin
                if (it.segment_index >= segs_used || seg_fill[it.segment_index] == 0) begin
                    st = ST_BAD;
                end else begin
                    seg_fill[it.segment_index]--;
                    release_empty_tail();
                end
            end
            default: begin
            end
        endcase
        res.status = st;
        res.segments_used = segs_used[4:0];
        if (segs_used == 0 || seg_fill[segs_used - 1] == 0)
            res.top_value = '0;
        else
            res.top_value = seg_mem[segs_used - 1][seg_fill[segs_used - 1] - 1];
    endtask

    function automatic t_in_item random_item(int mode);
        t_in_item    it;
        int unsigned r;
        int unsigned push_lim;
        int unsigned pop_lim;
        push_lim = (mode == MODE_GROW) ? 72 : (mode == MODE_SHRINK) ? 22 : 45;
        pop_lim  = (mode == MODE_GROW) ? 82 : (mode == MODE_SHRINK) ? 55 : 68;
        it.value = $urandom;
        it.segment_index = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < push_lim)
            it.operation = OP_PUSH;
        else if (r < pop_lim)
            it.operation = OP_POP;
        else if (r < 97)
            it.operation = OP_POP_AT;
        else
            it.operation = OP_NONE;
        if (it.operation == OP_POP_AT && segs_used > 0 && $urandom_range(0, 4) != 0)
            it.segment_index = 4'($urandom_range(0, segs_used - 1));
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        int unsigned gap;
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        stack_step(it, pred);
        expected_results = {expected_results, (typed ? want : pred)};
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        seg_cap = cap;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [31:0] val,
                           input logic [3:0] idx, input bit typed,
                           input logic [1:0] st, input logic [31:0] top,
                           input logic [4:0] used);
        t_stim_row row;
        row.item.operation = op;
        row.item.value = val;
        row.item.segment_index = idx;
        row.typed = typed;
        row.want.status = st;
        row.want.top_value = top;
        row.want.segments_used = used;
        directed_rows = {directed_rows, row};
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            stall_count++;
            if (stall_count % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (stall_count % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d top %0d segments %0d",
                             out_item.status, out_item.top_value, out_item.segments_used);
            end else begin
                want_r = expected_results.pop_front();
                results_checked++;
                if (want_r.status == ST_FULL)
                    full_seen++;
                if (want_r.status == ST_EMPTY)
                    empty_seen++;
                if (want_r.status == ST_BAD)
                    bad_seen++;
                if (out_item.status !== want_r.status
                        || out_item.top_value !== want_r.top_value
                        || out_item.segments_used !== want_r.segments_used) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch on result %0d: expected status %0d top %0d ",
                                  "segments %0d, got status %0d top %0d segments %0d"},
                                 results_checked, want_r.status, want_r.top_value,
                                 want_r.segments_used, out_item.status,
                                 out_item.top_value, out_item.segments_used);
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] caps [8];
        int               mode;
        int unsigned      drain;
        caps = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd17, 5'd3, 5'd2, 5'd8};
        segs_used = 0;
        seg_cap = CAP_RESET;
        foreach (seg_fill[i])
            seg_fill[i] = 0;
        burst_left = 8;
        gaps_on = 1'b1;
        stall_mode = 0;

        add_row(OP_POP,    32'h0000_0000, 4'h0, 1, ST_EMPTY, 32'h0000_0000, 5'd0);
        add_row(OP_POP_AT, 32'hFFFF_FFFF, 4'h0, 1, ST_BAD,   32'h0000_0000, 5'd0);
        add_row(OP_NONE,   32'hFFFF_FFFF, 4'hF, 1, ST_OK,    32'h0000_0000, 5'd0);
        add_row(OP_PUSH,   32'h7FFF_FFFF, 4'h5, 1, ST_OK,    32'h7FFF_FFFF, 5'd1);
        add_row(OP_PUSH,   32'h8000_0000, 4'hA, 1, ST_OK,    32'h8000_0000, 5'd1);
        add_row(OP_PUSH,   32'hFFFF_FFFF, 4'hF, 1, ST_OK,    32'hFFFF_FFFF, 5'd2);
        add_row(OP_PUSH,   32'h0000_0000, 4'h0, 1, ST_OK,    32'h0000_0000, 5'd2);
        add_row(OP_PUSH,   32'h5555_5555, 4'h3, 1, ST_OK,    32'h5555_5555, 5'd3);
        add_row(OP_POP_AT, 32'h1234_5678, 4'h0, 0, ST_OK,    32'h0,         5'd0);
        add_row(OP_POP_AT, 32'h0000_0000, 4'hF, 1, ST_BAD,   32'h5555_5555, 5'd3);
        add_row(OP_POP_AT, 32'h0000_0000, 4'h0, 0, ST_OK,    32'h0,         5'd0);
        add_row(OP_POP_AT, 32'h0000_0000, 4'h0, 1, ST_BAD,   32'h5555_5555, 5'd3);
        add_row(OP_POP_AT, 32'hDEAD_BEEF, 4'h1, 0, ST_OK,    32'h0,         5'd0);
        add_row(OP_POP,    32'h0000_0000, 4'h9, 0, ST_OK,    32'h0,         5'd0);
        add_row(OP_POP_AT, 32'h0000_0000, 4'h1, 0, ST_OK,    32'h0,         5'd0);
        add_row(OP_POP,    32'h0000_0000, 4'h0, 1, ST_EMPTY, 32'h0000_0000, 5'd0);
        add_row(OP_PUSH,   32'hAAAA_AAAA, 4'hA, 1, ST_OK,    32'hAAAA_AAAA, 5'd1);
        add_row(OP_POP_AT, 32'h0000_0000, 4'h3, 1, ST_BAD,   32'hAAAA_AAAA, 5'd1);
        add_row(OP_NONE,   32'h0F0F_0F0F, 4'h0, 1, ST_OK,    32'hAAAA_AAAA, 5'd1);
        add_row(OP_POP,    32'h0000_0000, 4'h7, 1, ST_OK,    32'h0000_0000, 5'd0);

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset capacity of two is exercised before any register write.
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            while (expected_results.size() != 0)
                @(posedge i_clk);
            write_capacity(ph < 8 ? caps[ph] : CFG_W'($urandom_range(0, 31)));
            mode = (ph % 3 == 0) ? MODE_GROW : (ph % 3 == 1) ? MODE_SHRINK : MODE_MIX;
            gaps_on = (ph % 3 != 2) && (ph != 4);
            if (ph == 4)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(mode), 1'b0, '0);
            in_valid <= 1'b0;
        end

        while (expected_results.size() != 0)
            @(posedge i_clk);
        for (drain = 0; drain < 20; drain++)
            @(posedge i_clk);

        $display("Run covered %0d items and %0d checked results over %0d capacity settings.",
                 items_sent, results_checked, NUM_PHASES + 1);
        $display("Statuses seen: %0d full, %0d empty, %0d bad segment; %0d mismatches.",
                 full_seen, empty_seen, bad_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("segmented_stack_with_pop_at_test: PASS");
        else
            $display("segmented_stack_with_pop_at_test: FAIL");
        $finish;
    end

endmodule
